// ===== hdl/alu8bm_pkg.sv =====
package alu8bm_pkg;

    localparam int unsigned DataWidth  = 8;
    localparam int unsigned ResWidth   = 16;
    localparam int unsigned BoothSteps = 8;

    typedef enum logic [3:0] {
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_MUL = 4'd3,
        OP_AND = 4'd4,
        OP_OR  = 4'd5,
        OP_NOT = 4'd6,
        OP_XOR = 4'd7,
        OP_SHR = 4'd8,
        OP_SHL = 4'd9
    } t_opcode;

    // One request travelling down the Booth chain.
    typedef struct packed {
        logic                 valid;
        logic [3:0]           opcode;
        logic [DataWidth-1:0] mcand;   // multiplicand
        logic [DataWidth-1:0] acc;     // Booth A
        logic [DataWidth-1:0] q;       // Booth Q
        logic                 qm1;     // Booth Q-1
        logic [DataWidth:0]   alt;     // result of every non-multiply opcode
    } t_stage;

    typedef struct packed {
        logic [ResWidth-1:0] value;
        logic                zero;
        logic                carry;
        logic                sign;
        logic                ovf;
    } t_result;

endpackage

// ===== hdl/alu8bm_cell.sv =====
// One Booth radix-2 step, registered; passes the rest of the request along.
module alu8bm_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  alu8bm_pkg::t_stage   i_stage,
    output alu8bm_pkg::t_stage   o_stage
);

    alu8bm_pkg::t_stage r_stage;
    alu8bm_pkg::t_stage n_stage;
    logic [alu8bm_pkg::DataWidth-1:0] w_sum;

    always_comb begin
        case ({i_stage.q[0], i_stage.qm1})
            2'b10:   w_sum = i_stage.acc - i_stage.mcand;
            2'b01:   w_sum = i_stage.acc + i_stage.mcand;
            default: w_sum = i_stage.acc;
        endcase
        n_stage       = i_stage;
        // arithmetic shift of A:Q:Q-1
        n_stage.acc   = {w_sum[alu8bm_pkg::DataWidth-1], w_sum[alu8bm_pkg::DataWidth-1:1]};
        n_stage.q     = {w_sum[0], i_stage.q[alu8bm_pkg::DataWidth-1:1]};
        n_stage.qm1   = i_stage.q[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.opcode <= n_stage.opcode;
            r_stage.mcand  <= n_stage.mcand;
            r_stage.acc    <= n_stage.acc;
            r_stage.q      <= n_stage.q;
            r_stage.qm1    <= n_stage.qm1;
            r_stage.alt    <= n_stage.alt;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hdl/alu8bm_result.sv =====
// Picks the final value and derives the flags from the full value.
module alu8bm_result (
    input  alu8bm_pkg::t_stage  i_stage,
    output alu8bm_pkg::t_result o_result
);

    logic [alu8bm_pkg::ResWidth-1:0] w_value;

    always_comb begin
        if (i_stage.opcode == alu8bm_pkg::OP_MUL) begin
            w_value = {i_stage.acc, i_stage.q};
        end else begin
            w_value = {{(alu8bm_pkg::ResWidth-alu8bm_pkg::DataWidth-1){1'b0}}, i_stage.alt};
        end
        o_result.value = w_value;
        o_result.zero  = (w_value == '0);
        o_result.carry = |w_value[alu8bm_pkg::ResWidth-1:alu8bm_pkg::DataWidth];
        o_result.sign  = w_value[alu8bm_pkg::DataWidth-1];
        o_result.ovf   = |w_value[alu8bm_pkg::ResWidth-1:alu8bm_pkg::DataWidth-1];
    end

endmodule

// ===== hdl/alu8bm_booth_multiply_flags.sv =====
// 8-bit ALU with signed Booth radix-2 multiplier and zero/carry/sign/overflow flags.
//
// Channels: request in (i_in_valid / o_in_ready, with i_opcode, i_operand_a,
// i_operand_b) and result out (o_out_valid / i_out_ready, with o_result and
// the four flags). Both transfer on a clock edge where valid and ready are high.
//
// Every request, multiply or not, walks the same chain of eight Booth cells,
// one Booth step per cell, then lands in the output register, which drives
// o_out_valid. Throughput is one request per cycle while the output is not stalled.
// The chain length is one cell per multiplier bit.
//
// The chain and output register advance together whenever the output register
// is empty or being drained. If the receiver holds i_out_ready low with a
// result waiting, the whole chain freezes and o_in_ready drops in the same
// cycle; nothing is lost or repeated. Up to nine requests can be in flight.
//
// Reset (i_rst_n low, synchronous) clears every valid bit; data registers keep
// whatever they hold and are ignored until refilled.
module alu_8bit_booth_multiply_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_operand_a,
    input  logic [7:0]  i_operand_b,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_result,
    output logic        o_zero_flag,
    output logic        o_carry_flag,
    output logic        o_sign_flag,
    output logic        o_overflow_flag
);

    // chain advance: output slot free or being taken
    logic w_en;

    alu8bm_pkg::t_stage  w_stage [0:alu8bm_pkg::BoothSteps];
    alu8bm_pkg::t_result w_res;
    alu8bm_pkg::t_result r_res;
    logic                r_out_valid;
    logic [alu8bm_pkg::DataWidth:0] w_alt;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Non-multiply opcodes are resolved here and ride the chain untouched.
    always_comb begin
        case (i_opcode)
            alu8bm_pkg::OP_ADD: w_alt = {1'b0, i_operand_a} + {1'b0, i_operand_b};
            // a plus two's complement of b, 9-bit sum
            alu8bm_pkg::OP_SUB: w_alt = {1'b0, i_operand_a} + {1'b0, (8'd0 - i_operand_b)};
            alu8bm_pkg::OP_AND: w_alt = {1'b0, i_operand_a & i_operand_b};
            alu8bm_pkg::OP_OR:  w_alt = {1'b0, i_operand_a | i_operand_b};
            alu8bm_pkg::OP_NOT: w_alt = {1'b0, ~i_operand_a};
            alu8bm_pkg::OP_XOR: w_alt = {1'b0, i_operand_a ^ i_operand_b};
            alu8bm_pkg::OP_SHR: w_alt = {2'b00, i_operand_a[7:1]};
            alu8bm_pkg::OP_SHL: w_alt = {1'b0, i_operand_a[6:0], 1'b0};
            default:            w_alt = '0;   // multiply and unknown opcodes
        endcase
    end

    // Chain head: Booth registers start at A=0, Q=b, Q-1=0.
    always_comb begin
        w_stage[0].valid  = i_in_valid;
        w_stage[0].opcode = i_opcode;
        w_stage[0].mcand  = i_operand_a;
        w_stage[0].acc    = '0;
        w_stage[0].q      = i_operand_b;
        w_stage[0].qm1    = 1'b0;
        w_stage[0].alt    = w_alt;
    end

    for (genvar g = 0; g < alu8bm_pkg::BoothSteps; g++) begin : g_cell
        alu8bm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    alu8bm_result u_result (
        .i_stage  (w_stage[alu8bm_pkg::BoothSteps]),
        .o_result (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_stage[alu8bm_pkg::BoothSteps].valid;
        end
        if (w_en) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result        = r_res.value;
    assign o_zero_flag     = r_res.zero;
    assign o_carry_flag    = r_res.carry;
    assign o_sign_flag     = r_res.sign;
    assign o_overflow_flag = r_res.ovf;

    // Assertions
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output slot");

    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_stage[alu8bm_pkg::BoothSteps].valid))
        else $error("chain moved while stalled");

    a_carry_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_carry_flag |-> o_overflow_flag)
        else $error("carry set without overflow");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_zero_flag == (o_result == 16'd0)))
        else $error("zero flag mismatch");

endmodule

// ===== tb/alu_8bit_booth_multiply_flags_test.sv =====
`timescale 1ns / 1ps

// Tracks every accepted request, predicts its ALU result and compares the
// results coming out of the block in order.
class alu_result_tracker;

    alu8bm_pkg::t_result expected_results[$];
    int                  mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Radix-2 Booth over 8 steps; A wraps at 8 bits, shift copies A[7].
    function logic [15:0] booth_product(logic [7:0] mcand, logic [7:0] mplier);
        logic [7:0] acc;
        logic [7:0] q;
        logic       qm1;
        acc = '0;
        q   = mplier;
        qm1 = 1'b0;
        for (int i = 0; i < alu8bm_pkg::BoothSteps; i++) begin
            case ({q[0], qm1})
                2'b10: acc = acc - mcand;
                2'b01: acc = acc + mcand;
                default: ;
            endcase
            qm1 = q[0];
            q   = {acc[0], q[7:1]};
            acc = {acc[7], acc[7:1]};
        end
        return {acc, q};
    endfunction

    function alu8bm_pkg::t_result predict_alu(logic [3:0] op, logic [7:0] a, logic [7:0] b);
        alu8bm_pkg::t_result res;
        logic [7:0]          neg_b;
        neg_b = ~b + 8'd1;
        case (op)
            alu8bm_pkg::OP_ADD: res.value = 16'(a) + 16'(b);
            alu8bm_pkg::OP_SUB: res.value = 16'(a) + 16'(neg_b);
            alu8bm_pkg::OP_MUL: res.value = booth_product(a, b);
            alu8bm_pkg::OP_AND: res.value = 16'(a & b);
            alu8bm_pkg::OP_OR:  res.value = 16'(a | b);
            // invert within the byte, high byte stays clear
            alu8bm_pkg::OP_NOT: res.value = {8'h00, ~a};
            alu8bm_pkg::OP_XOR: res.value = 16'(a ^ b);
            alu8bm_pkg::OP_SHR: res.value = 16'(a >> 1);
            alu8bm_pkg::OP_SHL: res.value = 16'(8'(a << 1));
            default:            res.value = '0;
        endcase
        // flags look at the full value, not just the low byte
        res.zero  = (res.value == 16'd0);
        res.carry = (res.value > 16'd255);
        res.sign  = res.value[7];
        res.ovf   = (res.value > 16'd127);
        return res;
    endfunction

    function void note_request(logic [3:0] op, logic [7:0] a, logic [7:0] b);
        expected_results.push_back(predict_alu(op, a, b));
    endfunction

    function void check_result(alu8bm_pkg::t_result got);
        alu8bm_pkg::t_result exp_res;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result value=%h flags z%b c%b s%b v%b", $realtime,
                     got.value, got.zero, got.carry, got.sign, got.ovf);
            mismatches++;
            return;
        end
        exp_res = expected_results.pop_front();
        if (got.value !== exp_res.value) begin
            $display("%0t: result expected %h actual %h", $realtime, exp_res.value, got.value);
            mismatches++;
        end
        if (got.zero !== exp_res.zero) begin
            $display("%0t: zero_flag expected %b actual %b", $realtime, exp_res.zero, got.zero);
            mismatches++;
        end
        if (got.carry !== exp_res.carry) begin
            $display("%0t: carry_flag expected %b actual %b", $realtime,
                     exp_res.carry, got.carry);
            mismatches++;
        end
        if (got.sign !== exp_res.sign) begin
            $display("%0t: sign_flag expected %b actual %b", $realtime, exp_res.sign, got.sign);
            mismatches++;
        end
        if (got.ovf !== exp_res.ovf) begin
            $display("%0t: overflow_flag expected %b actual %b", $realtime,
                     exp_res.ovf, got.ovf);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module alu_8bit_booth_multiply_flags_test;

    // opcodes with no operation behind them
    localparam logic [3:0] OP_UNUSED_ZERO  = 4'd0;
    localparam logic [3:0] OP_UNUSED_FIRST = 4'd10;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    localparam int RANDOM_REQUESTS = 500;
    localparam int DRAIN_CYCLES    = 24;      // chain is 8 deep plus output reg
    localparam int CYCLE_LIMIT     = 200000;  // ~525 requests x worst gap+stall, padded

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [3:0]  i_opcode;
    logic [7:0]  i_operand_a;
    logic [7:0]  i_operand_b;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_result;
    logic        o_zero_flag;
    logic        o_carry_flag;
    logic        o_sign_flag;
    logic        o_overflow_flag;

    alu_result_tracker tracker;
    int                cycle_count;
    bit                no_gaps;

    alu_8bit_booth_multiply_flags u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result        (o_result),
        .o_zero_flag     (o_zero_flag),
        .o_carry_flag    (o_carry_flag),
        .o_sign_flag     (o_sign_flag),
        .o_overflow_flag (o_overflow_flag)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Bias toward the byte corners that matter for flags and Booth signs.
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
        if ($urandom_range(0, 4) == 0)
            return corners[$urandom_range(0, 4)];
        return 8'($urandom);
    endfunction

    function automatic logic [3:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return 4'($urandom_range(alu8bm_pkg::OP_ADD, alu8bm_pkg::OP_SHL));
        if (r < 91)
            return OP_UNUSED_ZERO;
        return 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    endfunction

    // Present one request and hold it until the block takes it. Called at a
    // rising edge; returns at the edge where the request was accepted.
    task automatic drive_request(input logic [3:0] op, input logic [7:0] a,
                                 input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_request(op, a, b);
    endtask

    // Receiver: runs of ready broken by stalls; long runs give stall-free stretches.
    initial begin
        int run;
        int stall;
        int r;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 70)
                stall = $urandom_range(1, 3);
            else if (r < 95)
                stall = $urandom_range(4, 10);
            else
                stall = $urandom_range(20, 40);
            i_out_ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
    end

    // Result monitor: sampled at the edge, before any of this step's updates land.
    always @(posedge i_clk) begin
        alu8bm_pkg::t_result got;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got.value = o_result;
            got.zero  = o_zero_flag;
            got.carry = o_carry_flag;
            got.sign  = o_sign_flag;
            got.ovf   = o_overflow_flag;
            tracker.check_result(got);
        end
    end

    initial begin
        tracker     = new();
        no_gaps     = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_UNUSED_ZERO;
        i_operand_a <= 8'h00;
        i_operand_b <= 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners of each operation.
        drive_request(alu8bm_pkg::OP_ADD, 8'h00, 8'h00);   // zero
        drive_request(alu8bm_pkg::OP_ADD, 8'hFF, 8'hFF);   // 9-bit sum, carry
        drive_request(alu8bm_pkg::OP_ADD, 8'h7F, 8'h01);   // crosses 127
        drive_request(alu8bm_pkg::OP_SUB, 8'h5A, 8'h00);   // subtract zero gives a
        drive_request(alu8bm_pkg::OP_SUB, 8'h00, 8'h01);
        drive_request(alu8bm_pkg::OP_SUB, 8'hFF, 8'hFF);
        drive_request(alu8bm_pkg::OP_MUL, 8'h7F, 8'h80);
        drive_request(alu8bm_pkg::OP_MUL, 8'h80, 8'h80);
        drive_request(alu8bm_pkg::OP_MUL, 8'hFF, 8'hFF);
        drive_request(alu8bm_pkg::OP_MUL, 8'h00, 8'hA5);
        drive_request(alu8bm_pkg::OP_MUL, 8'h03, 8'h09);
        drive_request(alu8bm_pkg::OP_AND, 8'hFF, 8'hFF);
        drive_request(alu8bm_pkg::OP_AND, 8'hF0, 8'h0F);
        drive_request(alu8bm_pkg::OP_OR,  8'h00, 8'h00);
        drive_request(alu8bm_pkg::OP_OR,  8'h80, 8'h7F);
        drive_request(alu8bm_pkg::OP_NOT, 8'h00, 8'hFF);
        drive_request(alu8bm_pkg::OP_NOT, 8'hFF, 8'h00);
        drive_request(alu8bm_pkg::OP_XOR, 8'hFF, 8'h55);
        drive_request(alu8bm_pkg::OP_SHR, 8'hFF, 8'hFF);
        drive_request(alu8bm_pkg::OP_SHR, 8'h01, 8'h00);   // shifts out to zero
        drive_request(alu8bm_pkg::OP_SHL, 8'h80, 8'h00);   // truncated to zero
        drive_request(alu8bm_pkg::OP_SHL, 8'hFF, 8'hFF);
        drive_request(OP_UNUSED_ZERO, 8'hFF, 8'hFF);        // unknown opcodes
        drive_request(OP_UNUSED_FIRST, 8'hFF, 8'hFF);
        drive_request(OP_UNUSED_LAST, 8'h80, 8'h7F);

        // Random requests; every 50 pick whether the sender runs flat out.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 50 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            drive_request(pick_opcode(), pick_byte(), pick_byte());
        end
        i_in_valid <= 1'b0;

        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
